/* rtl/atce_pkg.sv */
package atce_pkg;

  localparam int MAX_VALUES  = 8;
  localparam int TAB_STOP    = 4;
  localparam int VIDX_W      = $clog2(MAX_VALUES);
  localparam int VCNT_W      = $clog2(MAX_VALUES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  ESC_BYTE   = 8'h1B;
  localparam logic [7:0]  COLS_RESET = 8'd80;
  localparam logic [7:0]  ROWS_RESET = 8'd25;
  localparam logic [23:0] FG_RESET   = 24'hFFFFFF;
  localparam logic [23:0] BG_RESET   = 24'h000000;

  // register indexes on the configuration port
  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_FG   = 2'd2;
  localparam logic [1:0] REG_BG   = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PRINT,
    OP_SAVE,
    OP_RESTORE,
    OP_PUSH,
    OP_SGR,
    OP_POS,
    OP_CLEAR,
    OP_ERR,
    OP_HOME
  } op_t;

  // value: accumulator at classification time; count: stored values before it
  typedef struct packed {
    op_t               op;
    logic [7:0]        code;
    logic [15:0]       value;
    logic [VCNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [23:0] fg;
    logic [23:0] bg;
  } colour_t;

  typedef struct packed {
    logic [7:0]  cols;
    logic [7:0]  rows;
    logic [23:0] dfg;
    logic [23:0] dbg;
  } cfg_t;

  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'hAA0000;
      4'd2:    rgb = 24'h00AA00;
      4'd3:    rgb = 24'hAA5500;
      4'd4:    rgb = 24'h0000AA;
      4'd5:    rgb = 24'hAA00AA;
      4'd6:    rgb = 24'h00AAAA;
      4'd7:    rgb = 24'hAAAAAA;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'hFF5555;
      4'd10:   rgb = 24'h55FF55;
      4'd11:   rgb = 24'hFFFF55;
      4'd12:   rgb = 24'h5555FF;
      4'd13:   rgb = 24'hFF55FF;
      4'd14:   rgb = 24'h55FFFF;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

  // one SGR code; unknown codes leave the colours alone
  function automatic colour_t sgr_apply(input logic [15:0] v, input colour_t cur,
                                        input colour_t dflt);
    colour_t     res;
    logic [15:0] off;
    res = cur;
    off = 16'd0;
    if (v == 16'd0) begin
      res = dflt;
    end else if (v >= 16'd30 && v <= 16'd37) begin
      off    = v - 16'd30;
      res.fg = palette({1'b0, off[2:0]});
    end else if (v >= 16'd40 && v <= 16'd47) begin
      off    = v - 16'd40;
      res.bg = palette({1'b0, off[2:0]});
    end else if (v >= 16'd90 && v <= 16'd97) begin
      off    = v - 16'd90;
      res.fg = palette({1'b1, off[2:0]});
    end else if (v >= 16'd100 && v <= 16'd107) begin
      off    = v - 16'd100;
      res.bg = palette({1'b1, off[2:0]});
    end
    return res;
  endfunction

endpackage

/* rtl/ansi_text_console_engine.sv */
// Text console engine: console bytes in, glyph draws and cursor/colour state out.
// Input channel (in_valid/in_ready): in_action = 1 homes the cursor and restores
// the default colours; otherwise in_char_byte is parsed (ESC [ sequences for
// cursor save/restore, SGR colours, cursor position and 2J clear) or printed.
// Output channel (out_valid/out_ready): exactly one result item per input item,
// in order, held in an output register until taken.
// A classifier accepts items into a two-entry command queue; an executor drains
// it. Accepted items pass through the queue, then the output register. Most
// items sustain one per cycle while out_ready is high; an SGR terminator
// with k stored values occupies the executor, one stored value applied per cycle.
// When out_ready is low the output register holds, the executor waits and the
// queue fills; in_ready drops once the queue is full.
// Configuration (APB, pready always high): 0 screen_columns, 1 screen_rows,
// 2 default_foreground, 3 default_background, at byte addresses 4*i. Write
// only while the block is idle.
// Reset (rst_n low, synchronous) gives 80x25, white on black, cursor at 0,0,
// normal text parsing and empty queue and output register.
module ansi_text_console_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_draw_glyph,
  output logic [7:0]  out_glyph_code,
  output logic [7:0]  out_glyph_column,
  output logic [7:0]  out_glyph_row,
  output logic [23:0] out_foreground_rgb,
  output logic [23:0] out_background_rgb,
  output logic        out_clear_screen,
  output logic        out_sequence_error,
  output logic [7:0]  out_cursor_column,
  output logic [7:0]  out_cursor_row,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]     cols_r, rows_r;
  logic [23:0]    dfg_r, dbg_r;
  logic           cfg_we;
  logic [1:0]     reg_idx;
  atce_pkg::cfg_t cfg;

  logic           q_full, q_empty, q_push, q_pop;
  atce_pkg::cmd_t push_cmd, pop_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= atce_pkg::COLS_RESET;
      rows_r <= atce_pkg::ROWS_RESET;
      dfg_r  <= atce_pkg::FG_RESET;
      dbg_r  <= atce_pkg::BG_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx)
        atce_pkg::REG_COLS: cols_r <= pwdata[7:0];
        atce_pkg::REG_ROWS: rows_r <= pwdata[7:0];
        atce_pkg::REG_FG:   dfg_r  <= pwdata[23:0];
        atce_pkg::REG_BG:   dbg_r  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      atce_pkg::REG_COLS: prdata = {24'd0, cols_r};
      atce_pkg::REG_ROWS: prdata = {24'd0, rows_r};
      atce_pkg::REG_FG:   prdata = {8'd0, dfg_r};
      atce_pkg::REG_BG:   prdata = {8'd0, dbg_r};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg.cols = cols_r;
  assign cfg.rows = rows_r;
  assign cfg.dfg  = dfg_r;
  assign cfg.dbg  = dbg_r;

  atce_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_char_byte (in_char_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  atce_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  atce_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_empty            (q_empty),
    .q_cmd              (pop_cmd),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_draw_glyph     (out_draw_glyph),
    .out_glyph_code     (out_glyph_code),
    .out_glyph_column   (out_glyph_column),
    .out_glyph_row      (out_glyph_row),
    .out_foreground_rgb (out_foreground_rgb),
    .out_background_rgb (out_background_rgb),
    .out_clear_screen   (out_clear_screen),
    .out_sequence_error (out_sequence_error),
    .out_cursor_column  (out_cursor_column),
    .out_cursor_row     (out_cursor_row)
  );

endmodule

/* rtl/atce_front.sv */
module atce_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [7:0]       in_char_byte,
  input  logic             q_full,
  output logic             q_push,
  output atce_pkg::cmd_t   q_cmd
);

  localparam logic [1:0] PH_NORMAL  = 2'd0;
  localparam logic [1:0] PH_ESC     = 2'd1;
  localparam logic [1:0] PH_BRACKET = 2'd2;
  localparam logic [1:0] PH_VALUE   = 2'd3;

  logic [1:0]                  phase_r, phase_nxt;
  logic [15:0]                 acc_r, acc_nxt;
  logic [atce_pkg::VCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        end_seq;
  logic                        is_digit;
  logic [7:0]                  digit8;
  logic [15:0]                 digit;
  logic [15:0]                 acc_x10;
  logic [7:0]                  c;

  assign c        = in_char_byte;
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign digit8   = c - 8'h30;
  assign digit    = {12'd0, digit8[3:0]};
  assign acc_x10  = (acc_r << 3) + (acc_r << 1);

  always_comb begin
    q_cmd.op    = atce_pkg::OP_NOP;
    q_cmd.code  = c;
    q_cmd.value = acc_r;
    q_cmd.count = cnt_r;
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    end_seq     = 1'b0;
    if (in_action) begin
      // parse state is kept across a home
      q_cmd.op = atce_pkg::OP_HOME;
    end else begin
      unique case (phase_r)
        PH_NORMAL: begin
          if (c == atce_pkg::ESC_BYTE) begin
            phase_nxt = PH_ESC;
          end else begin
            q_cmd.op = atce_pkg::OP_PRINT;
            end_seq  = 1'b1;
          end
        end
        PH_ESC: begin
          if (c == "[") begin
            phase_nxt = PH_BRACKET;
          end else begin
            q_cmd.op = atce_pkg::OP_PRINT;
            end_seq  = 1'b1;
          end
        end
        PH_BRACKET: begin
          if (is_digit) begin
            acc_nxt   = digit;
            phase_nxt = PH_VALUE;
          end else if (c == "s") begin
            q_cmd.op = atce_pkg::OP_SAVE;
            end_seq  = 1'b1;
          end else if (c == "u") begin
            q_cmd.op = atce_pkg::OP_RESTORE;
            end_seq  = 1'b1;
          end else begin
            q_cmd.op = atce_pkg::OP_PRINT;
            end_seq  = 1'b1;
          end
        end
        default: begin
          if (is_digit) begin
            acc_nxt = acc_x10 + digit;
          end else if (c == ";") begin
            if (cnt_r < atce_pkg::VCNT_W'(atce_pkg::MAX_VALUES)) begin
              q_cmd.op  = atce_pkg::OP_PUSH;
              cnt_nxt   = cnt_r + atce_pkg::VCNT_W'(1);
              acc_nxt   = 16'd0;
              phase_nxt = PH_BRACKET;
            end else begin
              q_cmd.op = atce_pkg::OP_ERR;
              end_seq  = 1'b1;
            end
          end else if (c == "m") begin
            if (cnt_r < atce_pkg::VCNT_W'(atce_pkg::MAX_VALUES)) begin
              q_cmd.op = atce_pkg::OP_SGR;
            end else begin
              q_cmd.op = atce_pkg::OP_ERR;
            end
            end_seq = 1'b1;
          end else if (c == "H" || c == "f") begin
            // at most line and column
            if (cnt_r < atce_pkg::VCNT_W'(2)) begin
              q_cmd.op = atce_pkg::OP_POS;
            end else begin
              q_cmd.op = atce_pkg::OP_ERR;
            end
            end_seq = 1'b1;
          end else if (c == "J") begin
            if (acc_r == 16'd2) begin
              q_cmd.op = atce_pkg::OP_CLEAR;
            end else begin
              q_cmd.op = atce_pkg::OP_ERR;
            end
            end_seq = 1'b1;
          end else begin
            q_cmd.op = atce_pkg::OP_PRINT;
            end_seq  = 1'b1;
          end
        end
      endcase
    end
    if (end_seq) begin
      phase_nxt = PH_NORMAL;
      acc_nxt   = 16'd0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      acc_r   <= 16'd0;
      cnt_r   <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* rtl/atce_fifo.sv */
module atce_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  atce_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output atce_pkg::cmd_t pop_cmd,
  output logic           empty
);

  atce_pkg::cmd_t              mem_r [atce_pkg::QUEUE_DEPTH];
  logic [atce_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [atce_pkg::QCNT_W-1:0] fill_r;

  assign full    = (fill_r == atce_pkg::QCNT_W'(atce_pkg::QUEUE_DEPTH));
  assign empty   = (fill_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  function automatic logic [atce_pkg::QPTR_W-1:0] ptr_inc(
    input logic [atce_pkg::QPTR_W-1:0] p);
    if (p == atce_pkg::QPTR_W'(atce_pkg::QUEUE_DEPTH - 1)) return '0;
    return p + atce_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      fill_r <= fill_r + atce_pkg::QCNT_W'(1);
      else if (pop && !push) fill_r <= fill_r - atce_pkg::QCNT_W'(1);
    end
  end

endmodule

/* rtl/atce_back.sv */
module atce_back (
  input  logic           clk,
  input  logic           rst_n,
  input  atce_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  atce_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_draw_glyph,
  output logic [7:0]     out_glyph_code,
  output logic [7:0]     out_glyph_column,
  output logic [7:0]     out_glyph_row,
  output logic [23:0]    out_foreground_rgb,
  output logic [23:0]    out_background_rgb,
  output logic           out_clear_screen,
  output logic           out_sequence_error,
  output logic [7:0]     out_cursor_column,
  output logic [7:0]     out_cursor_row
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [7:0]                  col_r, col_nxt, line_r, line_nxt;
  logic [7:0]                  sav_col_r, sav_col_nxt, sav_line_r, sav_line_nxt;
  atce_pkg::colour_t           colour_r, colour_nxt, dflt;
  logic [15:0]                 vlist_r [atce_pkg::MAX_VALUES];
  logic                        vl_we;
  logic [atce_pkg::VIDX_W-1:0] walk_idx_r, walk_idx_nxt;
  logic [atce_pkg::VCNT_W-1:0] walk_cnt_r, walk_cnt_nxt;
  logic [15:0]                 walk_val_r, walk_val_nxt;

  logic                        out_free, emit;
  logic                        o_draw, o_clear, o_err;
  logic [7:0]                  o_code, o_gcol, o_grow;

  logic                        out_valid_r;
  logic                        draw_r, clear_r, err_r;
  logic [7:0]                  code_r, gcol_r, grow_r, ocol_r, orow_r;
  logic [23:0]                 ofg_r, obg_r;

  logic [7:0]                  eff_cols, eff_rows;
  logic [8:0]                  pr_col, pr_line;
  logic                        pr_draw;
  logic [15:0]                 pos_line16, pos_col16, max_line16, max_col16;
  logic [7:0]                  pos_line, pos_col;

  assign eff_cols = (cfg.cols == 8'd0) ? 8'd1 : cfg.cols;
  assign eff_rows = (cfg.rows == 8'd0) ? 8'd1 : cfg.rows;
  assign dflt.fg  = cfg.dfg;
  assign dflt.bg  = cfg.dbg;
  assign out_free = !out_valid_r || out_ready;

  // printable byte or control character, then wrap and clamp to the last row
  always_comb begin
    pr_col  = {1'b0, col_r};
    pr_line = {1'b0, line_r};
    pr_draw = 1'b0;
    if (q_cmd.code == 8'h08) begin
      if (pr_col != 9'd0) pr_col = pr_col - 9'd1;
    end else if (q_cmd.code == 8'h0A) begin
      pr_col  = 9'd0;
      pr_line = pr_line + 9'd1;
    end else if (q_cmd.code == 8'h09) begin
      pr_col = pr_col - (pr_col % 9'(atce_pkg::TAB_STOP)) + 9'(atce_pkg::TAB_STOP);
    end else if (q_cmd.code == 8'h0D) begin
      pr_col = 9'd0;
    end else begin
      pr_draw = 1'b1;
      pr_col  = pr_col + 9'd1;
    end
    if (pr_col >= {1'b0, eff_cols}) begin
      pr_col  = 9'd0;
      pr_line = pr_line + 9'd1;
    end
    if (pr_line >= {1'b0, eff_rows}) begin
      pr_col  = 9'd0;
      pr_line = {1'b0, eff_rows} - 9'd1;
    end
  end

  // a lone value is the line; the column then goes to 0
  always_comb begin
    max_line16 = {8'd0, eff_rows} - 16'd1;
    max_col16  = {8'd0, eff_cols} - 16'd1;
    if (q_cmd.count == '0) begin
      pos_line16 = q_cmd.value;
      pos_col16  = 16'd0;
    end else begin
      pos_line16 = vlist_r[0];
      pos_col16  = q_cmd.value;
    end
    if (pos_line16 > max_line16) pos_line16 = max_line16;
    if (pos_col16 > max_col16)   pos_col16  = max_col16;
    pos_line = pos_line16[7:0];
    pos_col  = pos_col16[7:0];
  end

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    line_nxt     = line_r;
    sav_col_nxt  = sav_col_r;
    sav_line_nxt = sav_line_r;
    colour_nxt   = colour_r;
    walk_idx_nxt = walk_idx_r;
    walk_cnt_nxt = walk_cnt_r;
    walk_val_nxt = walk_val_r;
    vl_we        = 1'b0;
    q_pop        = 1'b0;
    emit         = 1'b0;
    o_draw       = 1'b0;
    o_code       = 8'd0;
    o_gcol       = 8'd0;
    o_grow       = 8'd0;
    o_clear      = 1'b0;
    o_err        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          unique case (q_cmd.op)
            atce_pkg::OP_NOP: ;
            atce_pkg::OP_PRINT: begin
              if (pr_draw) begin
                o_draw = 1'b1;
                o_code = q_cmd.code;
                o_gcol = col_r;
                o_grow = line_r;
              end
              col_nxt  = pr_col[7:0];
              line_nxt = pr_line[7:0];
            end
            atce_pkg::OP_SAVE: begin
              sav_col_nxt  = col_r;
              sav_line_nxt = line_r;
            end
            atce_pkg::OP_RESTORE: begin
              col_nxt  = sav_col_r;
              line_nxt = sav_line_r;
            end
            atce_pkg::OP_PUSH: vl_we = 1'b1;
            atce_pkg::OP_SGR: begin
              if (q_cmd.count == '0) begin
                colour_nxt = atce_pkg::sgr_apply(q_cmd.value, colour_r, dflt);
              end else begin
                // stored values first, one a cycle, then the final one
                emit         = 1'b0;
                walk_idx_nxt = '0;
                walk_cnt_nxt = q_cmd.count;
                walk_val_nxt = q_cmd.value;
                state_nxt    = S_WALK;
              end
            end
            atce_pkg::OP_POS: begin
              col_nxt  = pos_col;
              line_nxt = pos_line;
            end
            atce_pkg::OP_CLEAR: o_clear = 1'b1;
            atce_pkg::OP_ERR:   o_err = 1'b1;
            atce_pkg::OP_HOME: begin
              col_nxt    = 8'd0;
              line_nxt   = 8'd0;
              colour_nxt = dflt;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        colour_nxt = atce_pkg::sgr_apply(vlist_r[walk_idx_r], colour_r, dflt);
        if ((atce_pkg::VCNT_W'(walk_idx_r) + atce_pkg::VCNT_W'(1)) == walk_cnt_r) begin
          state_nxt = S_LAST;
        end else begin
          walk_idx_nxt = walk_idx_r + atce_pkg::VIDX_W'(1);
        end
      end
      S_LAST: begin
        if (out_free) begin
          colour_nxt = atce_pkg::sgr_apply(walk_val_r, colour_r, dflt);
          emit       = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vl_we) begin
      vlist_r[q_cmd.count[atce_pkg::VIDX_W-1:0]] <= q_cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= 8'd0;
      line_r      <= 8'd0;
      sav_col_r   <= 8'd0;
      sav_line_r  <= 8'd0;
      colour_r.fg <= atce_pkg::FG_RESET;
      colour_r.bg <= atce_pkg::BG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      line_r     <= line_nxt;
      sav_col_r  <= sav_col_nxt;
      sav_line_r <= sav_line_nxt;
      colour_r   <= colour_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    walk_idx_r <= walk_idx_nxt;
    walk_cnt_r <= walk_cnt_nxt;
    walk_val_r <= walk_val_nxt;
    if (emit) begin
      draw_r  <= o_draw;
      code_r  <= o_code;
      gcol_r  <= o_gcol;
      grow_r  <= o_grow;
      ofg_r   <= colour_nxt.fg;
      obg_r   <= colour_nxt.bg;
      clear_r <= o_clear;
      err_r   <= o_err;
      ocol_r  <= col_nxt;
      orow_r  <= line_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_draw_glyph     = draw_r;
  assign out_glyph_code     = code_r;
  assign out_glyph_column   = gcol_r;
  assign out_glyph_row      = grow_r;
  assign out_foreground_rgb = ofg_r;
  assign out_background_rgb = obg_r;
  assign out_clear_screen   = clear_r;
  assign out_sequence_error = err_r;
  assign out_cursor_column  = ocol_r;
  assign out_cursor_row     = orow_r;

endmodule

/* rtl/atce_checker.sv */
module atce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_draw_glyph,
  input logic [7:0]  out_glyph_code,
  input logic [7:0]  out_glyph_column,
  input logic [7:0]  out_glyph_row,
  input logic [23:0] out_foreground_rgb,
  input logic [23:0] out_background_rgb,
  input logic        out_clear_screen,
  input logic        out_sequence_error,
  input logic [7:0]  out_cursor_column,
  input logic [7:0]  out_cursor_row
);

  // a result item held back keeps its whole payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_draw_glyph)
      && $stable(out_glyph_code) && $stable(out_glyph_column) && $stable(out_glyph_row)
      && $stable(out_foreground_rgb) && $stable(out_background_rgb)
      && $stable(out_clear_screen) && $stable(out_sequence_error)
      && $stable(out_cursor_column) && $stable(out_cursor_row))
    else $error("result item changed while stalled");

  // no glyph means zero glyph fields
  a_glyph_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_draw_glyph |->
      out_glyph_code == 8'd0 && out_glyph_column == 8'd0 && out_glyph_row == 8'd0)
    else $error("glyph fields set without a draw");

  // draw, clear and error come from different bytes
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_draw_glyph && out_clear_screen)
      && !(out_draw_glyph && out_sequence_error)
      && !(out_clear_screen && out_sequence_error))
    else $error("more than one event in one result item");

  // no result item straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item valid after reset");

endmodule

bind ansi_text_console_engine atce_checker u_atce_checker (.*);
